[rtl/mft_pkg.sv]
// Shared types and constants for the multi-turn feedback tracker.
// Holds identifier bounds, scaling constants and the tracker status struct.
// No dependencies.
`default_nettype none

package mft_pkg;

    localparam logic [10:0] ID_LOW  = 11'h201;
    localparam logic [10:0] ID_HIGH = 11'h208;
    localparam logic [10:0] ID_BASE = 11'h200;

    localparam int          TURN_SHIFT   = 13;
    localparam logic [12:0] THR_RESET    = 13'd4096;

    // rotor: |a|*92160/8191 = 11*|a| + floor(2059*|a|/8191)
    localparam logic [3:0]  ROTOR_WHOLE  = 4'd11;
    localparam logic [11:0] ROTOR_FRAC   = 12'd2059;
    localparam logic [15:0] ANGLE_DIV    = 16'd8191;
    localparam logic [15:0] ANGLE_DIV2   = 16'd16382;

    // shaft: |s|*64/9 = 7*|s| + floor(|s|/9), floor(x/9) = (x*233017) >> 21
    localparam logic [2:0]  SHAFT_WHOLE  = 3'd7;
    localparam logic [17:0] SHAFT_RECIP  = 18'd233017;
    localparam int          SHAFT_SHIFT  = 21;

    localparam int TDATA_IN_W   = 48;
    localparam int TUSER_IN_W   = 11;
    localparam int TDATA_OUT_W  = 168;
    localparam int TUSER_OUT_W  = 5;

    typedef struct packed {
        logic               accepted;
        logic [3:0]         index;
        logic signed [31:0] round_count;
        logic signed [45:0] total_position;
    } t_track;

    typedef struct packed {
        logic signed [18:0] shaft_q8;
        logic signed [19:0] rotor_q8;
    } t_scale;

endpackage

`default_nettype wire

[rtl/mft_scale.sv]
// Fixed-point scaling of speed and angle into shaft speed and rotor degrees.
// Purely combinational, constant-reciprocal division; uses mft_pkg.
`default_nettype none

module mft_scale
    import mft_pkg::*;
(
    input  wire logic signed [15:0] i_angle,
    input  wire logic signed [15:0] i_speed,
    output t_scale                  o_scale
);

    logic [16:0] a_wide;
    logic [15:0] a_mag;
    logic [27:0] a_prod;
    logic [14:0] a_q0;
    logic [15:0] a_rem;
    logic [1:0]  a_corr;
    logic [19:0] a_res;
    logic [16:0] s_wide;
    logic [15:0] s_mag;
    logic [33:0] s_prod;
    logic [12:0] s_div;
    logic [18:0] s_res;

    always_comb begin
        a_wide = i_angle[15] ? (17'd0 - {i_angle[15], i_angle}) : {1'b0, i_angle};
        a_mag  = a_wide[15:0];
        a_prod = 28'(a_mag) * 28'(ROTOR_FRAC);
        a_q0   = a_prod[27:13];
        a_rem  = {3'b000, a_prod[12:0]} + {1'b0, a_q0};
        if (a_rem >= ANGLE_DIV2) begin
            a_corr = 2'd2;
        end else if (a_rem >= ANGLE_DIV) begin
            a_corr = 2'd1;
        end else begin
            a_corr = 2'd0;
        end
        a_res = 20'(a_mag) * 20'(ROTOR_WHOLE) + 20'(a_q0) + 20'(a_corr);
        o_scale.rotor_q8 = i_angle[15] ? (20'd0 - a_res) : a_res;

        s_wide = i_speed[15] ? (17'd0 - {i_speed[15], i_speed}) : {1'b0, i_speed};
        s_mag  = s_wide[15:0];
        s_prod = 34'(s_mag) * 34'(SHAFT_RECIP);
        s_div  = s_prod[33:SHAFT_SHIFT];
        s_res  = 19'(s_mag) * 19'(SHAFT_WHOLE) + 19'(s_div);
        o_scale.shaft_q8 = i_speed[15] ? (19'd0 - s_res) : s_res;
    end

endmodule

`default_nettype wire

[rtl/mft_track.sv]
// Multi-turn tracking state: zero offset, last angle and wrap count.
// Computes the round count and total angle for one frame; uses mft_pkg.
`default_nettype none

module mft_track
    import mft_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_update,
    input  wire logic [10:0]        i_can_id,
    input  wire logic signed [15:0] i_angle,
    input  wire logic [12:0]        i_thr,
    output t_track                  o_track,
    output logic                    o_offset_taken
);

    logic                r_offset_taken;
    logic signed [15:0]  r_offset;
    logic signed [15:0]  r_cur_angle;
    logic signed [31:0]  r_wrap;
    logic                in_range;
    logic signed [15:0]  prev_eff;
    logic signed [15:0]  off_eff;
    logic signed [17:0]  diff;
    logic signed [17:0]  thr_s;
    logic signed [17:0]  below;
    logic signed [17:0]  above;
    logic signed [31:0]  n_wrap;
    logic signed [45:0]  total;
    logic [10:0]         idx_full;

    always_comb begin
        in_range = i_can_id inside {[ID_LOW:ID_HIGH]};
        prev_eff = r_offset_taken ? r_cur_angle : i_angle;
        off_eff  = r_offset_taken ? r_offset : i_angle;
        diff     = 18'(i_angle) - 18'(prev_eff);
        thr_s    = {5'b00000, i_thr};
        below    = diff + thr_s;
        above    = thr_s - diff;
        if (below < 0) begin
            n_wrap = r_wrap + 32'sd1;
        end else if (above < 0) begin
            n_wrap = r_wrap - 32'sd1;
        end else begin
            n_wrap = r_wrap;
        end
        total = (46'(n_wrap) <<< TURN_SHIFT) + 46'(i_angle) - 46'(off_eff);
        idx_full = i_can_id - ID_BASE;

        o_track.accepted       = in_range;
        o_track.index          = in_range ? idx_full[3:0] : 4'd0;
        o_track.round_count    = in_range ? n_wrap : 32'sd0;
        o_track.total_position = in_range ? total : 46'sd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_taken <= 1'b0;
            r_offset       <= '0;
            r_cur_angle    <= '0;
            r_wrap         <= '0;
        end else if (i_update) begin
            r_offset_taken <= 1'b1;
            if (!r_offset_taken) begin
                r_offset <= i_angle;
            end
            if (in_range || !r_offset_taken) begin
                r_cur_angle <= i_angle;
            end
            if (in_range) begin
                r_wrap <= n_wrap;
            end
        end
    end

    assign o_offset_taken = r_offset_taken;

endmodule

`default_nettype wire

[rtl/motor_feedback_multiturn_tracker_top.sv]
// Multi-turn angle tracker for motor-controller feedback frames.
// Requests pass through an input register and a result register.
// Throughput: one request per cycle when not stalled; tracking state updates as a frame leaves the input register.
// Reset (synchronous, active low) clears the offset capture, angle and wrap state,
// empties both registers and sets the wrap threshold to 4096.
`default_nettype none

module motor_feedback_multiturn_tracker_top
    import mft_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [12:0]            i_cfg_wdata,    // wrap_threshold
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    input  wire logic [TDATA_IN_W-1:0]  i_s_tdata,      // byte0..byte5, byte0 lowest
    input  wire logic [TUSER_IN_W-1:0]  i_s_tuser,      // can_id
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    output logic [TDATA_OUT_W-1:0]      o_m_tdata,      // angle_raw, rotor_speed, motor_current,
                                                        // round_count, total_position,
                                                        // shaft_speed_q8, rotor_angle_q8, pad
    output logic [TUSER_OUT_W-1:0]      o_m_tuser       // accepted, controller_index
);

    logic [12:0]             r_thr;
    logic                    r_in_valid;
    logic [10:0]             r_in_id;
    logic [TDATA_IN_W-1:0]   r_in_data;
    logic                    r_out_valid;
    logic [TDATA_OUT_W-1:0]  r_out_data;
    logic [TUSER_OUT_W-1:0]  r_out_user;
    logic                    advance;
    logic signed [15:0]      angle;
    logic signed [15:0]      speed;
    logic signed [15:0]      current;
    t_track                  track;
    t_scale                  scale;
    logic                    offset_taken;
    logic [TDATA_OUT_W-1:0]  n_out_data;

    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    assign angle   = {r_in_data[7:0],   r_in_data[15:8]};
    assign speed   = {r_in_data[23:16], r_in_data[31:24]};
    assign current = {r_in_data[39:32], r_in_data[47:40]};

    mft_track u_track (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_update       (advance),
        .i_can_id       (r_in_id),
        .i_angle        (angle),
        .i_thr          (r_thr),
        .o_track        (track),
        .o_offset_taken (offset_taken)
    );

    mft_scale u_scale (
        .i_angle (angle),
        .i_speed (speed),
        .o_scale (scale)
    );

    always_comb begin
        if (track.accepted) begin
            n_out_data = {3'b000, scale.rotor_q8, scale.shaft_q8, track.total_position,
                          track.round_count, current, speed, angle};
        end else begin
            n_out_data = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_id   <= i_s_tuser;
            r_in_data <= i_s_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= n_out_data;
            r_out_user <= {track.index, track.accepted};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

    a_offset_after_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> offset_taken)
        else $error("offset not captured after first frame");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |-> (o_m_tdata == '0 && o_m_tuser[4:1] == 4'd0))
        else $error("rejected frame carries nonzero result");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tuser[4:1] != 4'd0 && o_m_tuser[4:1] <= 4'd8))
        else $error("accepted frame index out of range");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_out_valid) |=> r_out_valid)
        else $error("request lost between stages");

endmodule

`default_nettype wire
